@@ rtl/biv_pkg.sv @@
`timescale 1ns / 1ps
// Package for the boot image verifier: command, status and register codes,
// field widths and the hash lane start values. No dependencies.
package biv_pkg;

	// Commands carried in tuser
	localparam logic [2:0] CMD_START      = 3'd0;
	localparam logic [2:0] CMD_HEADER     = 3'd1;
	localparam logic [2:0] CMD_IMAGE      = 3'd2;
	localparam logic [2:0] CMD_HASH       = 3'd3;
	localparam logic [2:0] CMD_SIG        = 3'd4;
	localparam logic [2:0] CMD_VERIFY     = 3'd5;
	localparam logic [2:0] CMD_CLEAR_FAIL = 3'd6;

	// Result status codes
	localparam logic [3:0] ST_OK        = 4'd0;
	localparam logic [3:0] ST_SIG_BAD   = 4'd1;
	localparam logic [3:0] ST_ROLLBACK  = 4'd2;
	localparam logic [3:0] ST_HASH_BAD  = 4'd3;
	localparam logic [3:0] ST_CORRUPT   = 4'd4;
	localparam logic [3:0] ST_UNTRUSTED = 4'd5;
	localparam logic [3:0] ST_REVOKED   = 4'd6;
	localparam logic [3:0] ST_SIZE      = 4'd7;
	localparam logic [3:0] ST_CHECKSUM  = 4'd8;
	localparam logic [3:0] ST_ATTACK    = 4'd9;

	// Register indexes (byte address = 8 * index)
	localparam logic [2:0] REG_KEY0      = 3'd0;
	localparam logic [2:0] REG_KEY1      = 3'd1;
	localparam logic [2:0] REG_KEY2      = 3'd2;
	localparam logic [2:0] REG_KEY3      = 3'd3;
	localparam logic [2:0] REG_REVOKED   = 3'd4;
	localparam logic [2:0] REG_FAIL_LIM  = 3'd5;
	localparam logic [2:0] REG_MAX_BYTES = 3'd6;

	localparam int TYPE_SLOTS = 4;
	localparam int SLOT_W     = 2;
	localparam int LANES      = 8;
	localparam int SIZE_W     = 18;

	localparam logic [31:0] IMAGE_MAGIC = 32'h5345_4342;
	localparam logic [7:0]  FAIL_MAX   = 8'd255;
	localparam logic [7:0]  FAIL_LIMIT_RESET = 8'd5;
	localparam logic [SIZE_W-1:0] MAX_BYTES_RESET = 18'd131072;

	localparam logic [31:0] LANE_INIT [LANES] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam int IN_DATA_W  = 152;
	localparam int OUT_DATA_W = 48;

endpackage

@@ rtl/boot_image_verifier.sv @@
`timescale 1ns / 1ps
// Boot image verifier top level: input stage, per-image hash and compare
// state, ordered verify checks and result register. Depends on biv_pkg.
//
// The block takes one command item per cycle and keeps pace with a byte stream:
// every transfer on the input side lands in a single input register, and from
// there it is applied to the image state (header checksum, one of eight hash
// lanes, the running hash and signature compares) or, for a verify command,
// runs the whole check chain and loads the result register. A verify result
// thus passes through the input register and then the result register, and
// a new item is taken every cycle; the rate drops only while a finished verify
// result sits unread in the result register and another verify waits behind
// it. Each item sees the state left by the one before it, so commands act
// strictly in stream order. Start clears the per-image state but keeps the
// version store and failure count, which only reset, verify and (for the
// count) clear-failures touch. Configuration registers sit on an APB port at
// byte address 8*index and are meant to be written while no item is in flight.
module boot_image_verifier
	import biv_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// APB configuration port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [5:0]            paddr,
	input  logic [63:0]           pwdata,
	output logic [63:0]           prdata,
	output logic                  pready,
	// Command stream in
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// data_byte[7:0], magic_word[39:8], image_version[71:40],
	// image_length[103:72], image_kind[111:104], wanted_kind[113:112],
	// header_sum[145:114], zero fill[151:146]
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// command[2:0]
	input  logic [2:0]            s_axis_tuser,
	// Verify results out
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// status[3:0], failure_total[11:4], recorded_version[43:12], zero fill[47:44]
	output logic [OUT_DATA_W-1:0] m_axis_tdata
);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [63:0]       key_q [4];
	logic              revoked_q;
	logic [7:0]        fail_limit_q;
	logic [SIZE_W-1:0] max_bytes_q;
	logic              cfg_write;
	logic [2:0]        cfg_index;

	assign pready    = 1'b1;
	assign cfg_index = paddr[5:3];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				key_q[i] <= '0;
			end
			revoked_q    <= 1'b0;
			fail_limit_q <= FAIL_LIMIT_RESET;
			max_bytes_q  <= MAX_BYTES_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_KEY0:      key_q[0]     <= pwdata;
				REG_KEY1:      key_q[1]     <= pwdata;
				REG_KEY2:      key_q[2]     <= pwdata;
				REG_KEY3:      key_q[3]     <= pwdata;
				REG_REVOKED:   revoked_q    <= pwdata[0];
				REG_FAIL_LIM:  fail_limit_q <= pwdata[7:0];
				REG_MAX_BYTES: max_bytes_q  <= pwdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back the addressed register, zero-extended
	always_comb begin
		case (cfg_index)
			REG_KEY0:      prdata = key_q[0];
			REG_KEY1:      prdata = key_q[1];
			REG_KEY2:      prdata = key_q[2];
			REG_KEY3:      prdata = key_q[3];
			REG_REVOKED:   prdata = {63'd0, revoked_q};
			REG_FAIL_LIM:  prdata = {56'd0, fail_limit_q};
			REG_MAX_BYTES: prdata = {{(64-SIZE_W){1'b0}}, max_bytes_q};
			default:       prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Input register (stage 1)
	// ------------------------------------------------------------------
	logic        valid_s1;
	logic [2:0]  cmd_s1;
	logic [7:0]  byte_s1;
	logic [31:0] magic_s1;
	logic [31:0] version_s1;
	logic [31:0] length_s1;
	logic [7:0]  kind_s1;
	logic [1:0]  wanted_s1;
	logic [31:0] hsum_s1;

	logic        out_valid_q;
	logic        makes_result;
	logic        advance;
	logic        in_xfer;

	// Only verify produces a result; everything else retires without
	// touching the result register, so it never waits on the consumer.
	assign makes_result  = (cmd_s1 == CMD_VERIFY);
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready || !makes_result);
	assign s_axis_tready = !valid_s1 || advance;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// Payload needs no reset; load on every input transfer
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_s1     <= s_axis_tuser;
			byte_s1    <= s_axis_tdata[7:0];
			magic_s1   <= s_axis_tdata[39:8];
			version_s1 <= s_axis_tdata[71:40];
			length_s1  <= s_axis_tdata[103:72];
			kind_s1    <= s_axis_tdata[111:104];
			wanted_s1  <= s_axis_tdata[113:112];
			hsum_s1    <= s_axis_tdata[145:114];
		end
	end

	// ------------------------------------------------------------------
	// Per-image state
	// ------------------------------------------------------------------
	logic [31:0] lanes_q [LANES];
	logic [2:0]  lane_ptr_q;
	logic [31:0] header_acc_q;
	logic [4:0]  hash_pos_q;
	logic        hash_diff_q;
	logic [5:0]  sig_pos_q;
	logic        sig_diff_q;
	logic [31:0] vstore_q [TYPE_SLOTS];
	logic [7:0]  fail_count_q;

	// One lane read per item: the image byte, hash byte and signature byte
	// commands each pick the lane they need.
	logic [2:0]  lane_sel;
	logic [31:0] lane_rd;
	logic [1:0]  byte_sel;
	logic [7:0]  hash_byte;
	logic [63:0] key_word;
	logic [7:0]  key_byte;

	always_comb begin
		case (cmd_s1)
			CMD_IMAGE: begin
				lane_sel = lane_ptr_q;
				byte_sel = 2'd0;
			end
			CMD_HASH: begin
				lane_sel = hash_pos_q[4:2];
				byte_sel = hash_pos_q[1:0];
			end
			default: begin
				lane_sel = sig_pos_q[4:2];
				byte_sel = sig_pos_q[1:0];
			end
		endcase
	end

	assign lane_rd   = lanes_q[lane_sel];
	// Byte 0 of a lane is its top byte
	assign hash_byte = lane_rd[{~byte_sel, 3'b000} +: 8];
	assign key_word  = key_q[sig_pos_q[4:3]];
	assign key_byte  = key_word[{~sig_pos_q[2:0], 3'b000} +: 8];

	// Lane update: xor, rotate left by 7, add byte*31
	logic [31:0] lane_x;
	logic [31:0] lane_rot;
	logic [12:0] byte_x31;
	logic [31:0] lane_new;

	assign lane_x   = lane_rd ^ {24'd0, byte_s1};
	assign lane_rot = {lane_x[24:0], lane_x[31:25]};
	assign byte_x31 = {byte_s1, 5'd0} - {5'd0, byte_s1};
	assign lane_new = lane_rot + {19'd0, byte_x31};

	// Header checksum: add, then rotate left by one
	logic [31:0] hdr_sum;
	assign hdr_sum = header_acc_q + {24'd0, byte_s1};

	// ------------------------------------------------------------------
	// Verify checks, in priority order
	// ------------------------------------------------------------------
	logic [31:0] stored_ver;
	logic [3:0]  status;
	logic        count_fail;
	logic        raise_ver;
	logic [7:0]  fail_next;
	logic [31:0] recorded;

	assign stored_ver = vstore_q[wanted_s1];

	always_comb begin
		count_fail = 1'b0;
		if (magic_s1 != IMAGE_MAGIC) begin
			status = ST_CORRUPT;
		end else if ((kind_s1 != {6'd0, wanted_s1}) || (kind_s1 == 8'd0) ||
				(kind_s1 >= 8'(TYPE_SLOTS))) begin
			status = ST_UNTRUSTED;
		end else if ((length_s1 == 32'd0) ||
				(length_s1 > {{(32-SIZE_W){1'b0}}, max_bytes_q})) begin
			status = ST_SIZE;
		end else if (header_acc_q != hsum_s1) begin
			status = ST_CHECKSUM;
		end else if (revoked_q) begin
			status = ST_REVOKED;
		end else if (hash_diff_q) begin
			status     = ST_HASH_BAD;
			count_fail = 1'b1;
		end else if (sig_diff_q) begin
			status     = ST_SIG_BAD;
			count_fail = 1'b1;
		end else if (version_s1 < stored_ver) begin
			status     = ST_ROLLBACK;
			count_fail = 1'b1;
		end else if (fail_count_q >= fail_limit_q) begin
			status = ST_ATTACK;
		end else begin
			status = ST_OK;
		end
	end

	// Kind equals wanted on the ok path, so the wanted slot is the one written
	assign raise_ver = (status == ST_OK) && (version_s1 > stored_ver);
	assign fail_next = (count_fail && (fail_count_q != FAIL_MAX)) ?
		fail_count_q + 8'd1 : fail_count_q;
	assign recorded  = raise_ver ? version_s1 : stored_ver;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LANES; i++) begin
				lanes_q[i] <= LANE_INIT[i];
			end
			for (int i = 0; i < TYPE_SLOTS; i++) begin
				vstore_q[i] <= '0;
			end
			lane_ptr_q   <= '0;
			header_acc_q <= '0;
			hash_pos_q   <= '0;
			hash_diff_q  <= 1'b0;
			sig_pos_q    <= '0;
			sig_diff_q   <= 1'b0;
			fail_count_q <= '0;
		end else if (advance) begin
			case (cmd_s1)
				CMD_START: begin
					// Drop all per-image state; keep versions and the failure count
					for (int i = 0; i < LANES; i++) begin
						lanes_q[i] <= LANE_INIT[i];
					end
					lane_ptr_q   <= '0;
					header_acc_q <= '0;
					hash_pos_q   <= '0;
					hash_diff_q  <= 1'b0;
					sig_pos_q    <= '0;
					sig_diff_q   <= 1'b0;
				end
				CMD_HEADER: begin
					header_acc_q <= {hdr_sum[30:0], hdr_sum[31]};
				end
				CMD_IMAGE: begin
					lanes_q[lane_ptr_q] <= lane_new;
					lane_ptr_q          <= lane_ptr_q + 3'd1;
				end
				CMD_HASH: begin
					// Sticky mismatch flag; position wraps past the last byte
					if (hash_byte != byte_s1) begin
						hash_diff_q <= 1'b1;
					end
					hash_pos_q <= hash_pos_q + 5'd1;
				end
				CMD_SIG: begin
					if ((hash_byte ^ key_byte) != byte_s1) begin
						sig_diff_q <= 1'b1;
					end
					sig_pos_q <= sig_pos_q + 6'd1;
				end
				CMD_VERIFY: begin
					fail_count_q <= fail_next;
					if (raise_ver) begin
						vstore_q[wanted_s1] <= version_s1;
					end
				end
				CMD_CLEAR_FAIL: begin
					fail_count_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Result register
	// ------------------------------------------------------------------
	logic [OUT_DATA_W-1:0] out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && makes_result) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && makes_result) begin
			out_data_q <= {4'd0, recorded, fail_next, status};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// Failure count only falls on clear-failures
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (cmd_s1 != CMD_CLEAR_FAIL)) |=> (fail_count_q >= $past(fail_count_q)))
		else $error("failure count dropped without a clear");

	// A retired verify always leaves a result waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && makes_result) |=> out_valid_q)
		else $error("verify retired without a result");

	// Input side stalls only behind a held item
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && makes_result && out_valid_q))
		else $error("input stalled without cause");

	// Reported status is always a defined code
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_data_q[3:0] <= ST_ATTACK))
		else $error("status code out of range");

endmodule
